// ===== rtl/efe_pkg.sv =====
// Shared types, character codes and helper functions for the escape frame encoder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package efe_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_sum;
    typedef logic [1:0]  t_mode;

    // Most bytes one input item can cause.
    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    // Configuration port geometry: 64-bit registers at 8-byte spacing.
    localparam int DATA_W = 64;
    localparam int ADDR_W = 6;

    // Register indexes.
    localparam logic [2:0] REG_CTRL_BYTES    = 3'd0;
    localparam logic [2:0] REG_LINEFEED_BYTE = 3'd1;
    localparam logic [2:0] REG_SUM_MODE      = 3'd2;
    localparam logic [2:0] REG_SUM_BINARY    = 3'd3;
    localparam logic [2:0] REG_SUM_WORD      = 3'd4;
    localparam logic [2:0] REG_SUM_SKIP_CTRL = 3'd5;

    // Parser modes.
    localparam t_mode MODE_TEXT = 2'd0;
    localparam t_mode MODE_PCT  = 2'd1;
    localparam t_mode MODE_ESC  = 2'd2;
    localparam t_mode MODE_HEX  = 2'd3;

    // Checksum modes.
    localparam logic [1:0] SUM_ADD     = 2'd0;
    localparam logic [1:0] SUM_XOR     = 2'd1;
    localparam logic [1:0] SUM_XOR_INC = 2'd2;
    localparam logic [1:0] SUM_XOR_DEC = 2'd3;

    // Character codes.
    localparam t_byte CHAR_PERCENT   = 8'h25;
    localparam t_byte CHAR_BACKSLASH = 8'h5C;
    localparam t_byte CHAR_LBRACKET  = 8'h5B;
    localparam t_byte CHAR_RBRACKET  = 8'h5D;
    localparam t_byte CHAR_ZERO      = 8'h30;
    localparam t_byte CHAR_ONE       = 8'h31;
    localparam t_byte CHAR_NINE      = 8'h39;
    localparam t_byte CHAR_UPPER_A   = 8'h41;
    localparam t_byte CHAR_UPPER_F   = 8'h46;
    localparam t_byte CHAR_LOWER_T   = 8'h74;
    localparam t_byte CHAR_LOWER_R   = 8'h72;
    localparam t_byte CHAR_LOWER_N   = 8'h6E;
    localparam t_byte BYTE_TAB       = 8'h09;
    localparam t_byte BYTE_CR        = 8'h0D;
    localparam t_byte BYTE_LF        = 8'h0A;
    localparam t_byte LINEFEED_RESET = 8'h0A;
    localparam t_byte CASE_MASK      = 8'hDF;

    // Fold one byte into the running checksum.
    function automatic t_sum add_sum(input t_sum sum, input t_byte b, input logic [1:0] mode);
        if (mode != SUM_ADD) begin
            return sum ^ {8'h00, b};
        end
        return sum + {8'h00, b};
    endfunction

    // Map a character to its hex digit value; non-hex characters pass through unchecked.
    function automatic t_byte hex_digit(input t_byte c);
        t_byte v;
        v = c;
        if (v > CHAR_UPPER_F) begin
            v = v & CASE_MASK;
        end
        v = v - CHAR_ZERO;
        if (v > 8'd9) begin
            v = v - 8'd7;
        end
        return v;
    endfunction

    // Uppercase ASCII character for one nibble.
    function automatic t_byte nibble_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return CHAR_ZERO + {4'h0, v};
        end
        return CHAR_UPPER_A + {4'h0, v} - 8'd10;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/efe_ifs.sv =====
// Valid/ready channel interfaces: command characters in, frame bytes out.
// Depends on efe_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface efe_char_if;
    import efe_pkg::*;

    logic  valid;
    logic  ready;
    t_byte char_code;
    logic  first_of_frame;
    logic  last_of_frame;

    modport source (output valid, output char_code, output first_of_frame,
                    output last_of_frame, input ready);
    modport sink   (input valid, input char_code, input first_of_frame,
                    input last_of_frame, output ready);
endinterface

interface efe_byte_if;
    import efe_pkg::*;

    logic  valid;
    logic  ready;
    t_byte out_byte;
    logic  out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/escape_frame_encoder_with_checksum.sv =====
// Escape-coded frame encoder with running checksum: top level and only module.
// Depends on efe_pkg and the channel interfaces in efe_ifs.sv.
//
//   Port       Dir   Width  Carries
//   i_char     in    8+1+1  one command character with frame start/end flags
//   o_byte     out   8+1    one frame byte, flagged on the last byte of its item
//   APB        in    64     configuration registers at byte address 8*index
//
// An item is taken into an input register, decoded combinationally and loaded into a
// four-byte result register, from which its first byte is offered. Sustained rate is one
// item per cycle while o_byte.ready is high and each item causes at most one byte; an
// item causing n bytes holds the output port until all n are taken, one per handshake.
// Reset (synchronous, active low) clears the parser, checksum and registers to defaults.
// The input register holds one item while the result register waits on o_byte.ready;
// further items stall until the result register hands over its final byte.
`timescale 1ns / 1ps
`default_nettype none

module escape_frame_encoder_with_checksum (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    efe_char_if.sink                     i_char,
    efe_byte_if.source                   o_byte,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [efe_pkg::ADDR_W-1:0]   paddr,
    input  wire  [efe_pkg::DATA_W-1:0]   pwdata,
    output logic [efe_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import efe_pkg::*;

    // Configuration registers.
    logic [63:0] r_ctrl_bytes;
    t_byte       r_linefeed_byte;
    logic [1:0]  r_sum_mode;
    logic        r_sum_binary;
    logic        r_sum_word;
    logic        r_sum_skip_ctrl;

    // Input register.
    logic  r_in_valid;
    t_byte r_char;
    logic  r_first;
    logic  r_last;

    // Parser state.
    t_mode r_mode;
    t_byte r_acc;
    t_sum  r_sum;

    // Result register, drained from entry zero.
    t_byte            r_buf [MAX_RESULTS];
    logic [CNT_W-1:0] r_cnt;

    // Decode results.
    t_mode            n_mode;
    t_byte            n_acc;
    t_sum             n_sum;
    t_byte            n_buf [MAX_RESULTS];
    logic [CNT_W-1:0] n_cnt;

    logic  w_mode_text;
    t_mode w_mode0;
    t_byte w_acc0;
    t_sum  w_sum0;
    t_sum  w_sum_adj;
    t_byte w_ctrl;
    logic  w_cfg_write;
    logic  w_in_accept;
    logic  w_out_accept;
    logic  w_advance;

    // Handshakes: the decode step moves when the result register is empty or
    // hands over its final byte in this cycle.
    assign pready       = 1'b1;
    assign w_cfg_write  = psel && penable && pwrite && pready;
    assign w_out_accept = o_byte.valid && o_byte.ready;
    assign w_advance    = r_in_valid &&
                          ((r_cnt == '0) || ((r_cnt == CNT_W'(1)) && o_byte.ready));
    assign i_char.ready = !r_in_valid || w_advance;
    assign w_in_accept  = i_char.valid && i_char.ready;

    assign o_byte.valid    = (r_cnt != '0);
    assign o_byte.out_byte = r_buf[0];
    assign o_byte.out_last = (r_cnt == CNT_W'(1));

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_bytes    <= '0;
            r_linefeed_byte <= LINEFEED_RESET;
            r_sum_mode      <= SUM_ADD;
            r_sum_binary    <= 1'b0;
            r_sum_word      <= 1'b0;
            r_sum_skip_ctrl <= 1'b1;
        end else if (w_cfg_write) begin
            unique case (paddr[5:3])
                REG_CTRL_BYTES:    r_ctrl_bytes    <= pwdata;
                REG_LINEFEED_BYTE: r_linefeed_byte <= pwdata[7:0];
                REG_SUM_MODE:      r_sum_mode      <= pwdata[1:0];
                REG_SUM_BINARY:    r_sum_binary    <= pwdata[0];
                REG_SUM_WORD:      r_sum_word      <= pwdata[0];
                REG_SUM_SKIP_CTRL: r_sum_skip_ctrl <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Register reads.
    always_comb begin
        unique case (paddr[5:3])
            REG_CTRL_BYTES:    prdata = r_ctrl_bytes;
            REG_LINEFEED_BYTE: prdata = {56'h0, r_linefeed_byte};
            REG_SUM_MODE:      prdata = {62'h0, r_sum_mode};
            REG_SUM_BINARY:    prdata = {63'h0, r_sum_binary};
            REG_SUM_WORD:      prdata = {63'h0, r_sum_word};
            REG_SUM_SKIP_CTRL: prdata = {63'h0, r_sum_skip_ctrl};
            default:           prdata = '0;
        endcase
    end

    // Control byte for codes one to eight; code eight wraps to byte seven.
    assign w_ctrl = r_ctrl_bytes[{r_char[2:0] - 3'd1, 3'b000} +: 8];

    // Checksum as seen by an insert, with the increment or decrement applied.
    always_comb begin
        unique case (r_sum_mode)
            SUM_XOR_INC: w_sum_adj = w_sum0 + 16'd1;
            SUM_XOR_DEC: w_sum_adj = w_sum0 - 16'd1;
            default:     w_sum_adj = w_sum0;
        endcase
    end

    // Frame start clears the parser before the character is decoded.
    assign w_mode_text = r_first;
    assign w_mode0     = w_mode_text ? MODE_TEXT : r_mode;
    assign w_acc0      = r_first ? 8'h00 : r_acc;
    assign w_sum0      = r_first ? 16'h0000 : r_sum;

    // Decode one character into up to four bytes and the next parser state.
    always_comb begin
        n_mode = w_mode0;
        n_acc  = w_acc0;
        n_sum  = w_sum0;
        n_cnt  = '0;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            n_buf[k] = 8'h00;
        end

        unique case (w_mode0)
            MODE_TEXT: begin
                priority if (r_char == CHAR_PERCENT) begin
                    n_mode = MODE_PCT;
                end else if (r_char == CHAR_BACKSLASH) begin
                    n_mode = MODE_ESC;
                end else if (r_char == CHAR_LBRACKET) begin
                    n_mode = MODE_HEX;
                    n_acc  = 8'h00;
                end else begin
                    n_buf[0] = r_char;
                    n_cnt    = CNT_W'(1);
                    n_sum    = add_sum(w_sum0, r_char, r_sum_mode);
                end
            end
            MODE_PCT: begin
                n_mode = MODE_TEXT;
                priority if (r_char >= CHAR_ONE && r_char <= CHAR_NINE) begin
                    n_buf[0] = (r_char == CHAR_NINE) ? r_linefeed_byte : w_ctrl;
                    n_cnt    = CNT_W'(1);
                    if (!r_sum_skip_ctrl) begin
                        n_sum = add_sum(w_sum0, n_buf[0], r_sum_mode);
                    end
                end else if (r_char == CHAR_ZERO) begin
                    // Checksum insert: never folded back into the sum.
                    n_sum = w_sum_adj;
                    priority if (r_sum_binary && r_sum_word) begin
                        n_buf[0] = w_sum_adj[15:8];
                        n_buf[1] = w_sum_adj[7:0];
                        n_cnt    = CNT_W'(2);
                    end else if (r_sum_binary) begin
                        n_buf[0] = w_sum_adj[7:0];
                        n_cnt    = CNT_W'(1);
                    end else if (r_sum_word) begin
                        n_buf[0] = nibble_char(w_sum_adj[15:12]);
                        n_buf[1] = nibble_char(w_sum_adj[11:8]);
                        n_buf[2] = nibble_char(w_sum_adj[7:4]);
                        n_buf[3] = nibble_char(w_sum_adj[3:0]);
                        n_cnt    = CNT_W'(4);
                    end else begin
                        n_buf[0] = nibble_char(w_sum_adj[7:4]);
                        n_buf[1] = nibble_char(w_sum_adj[3:0]);
                        n_cnt    = CNT_W'(2);
                    end
                end else begin
                    n_buf[0] = r_char;
                    n_cnt    = CNT_W'(1);
                    n_sum    = add_sum(w_sum0, r_char, r_sum_mode);
                end
            end
            MODE_ESC: begin
                // Backslash escapes stay out of the checksum.
                n_mode = MODE_TEXT;
                n_cnt  = CNT_W'(1);
                priority if (r_char == CHAR_LOWER_T) begin
                    n_buf[0] = BYTE_TAB;
                end else if (r_char == CHAR_LOWER_R) begin
                    n_buf[0] = BYTE_CR;
                end else if (r_char == CHAR_LOWER_N) begin
                    n_buf[0] = BYTE_LF;
                end else begin
                    n_buf[0] = r_char;
                end
            end
            MODE_HEX: begin
                if (r_char == CHAR_RBRACKET) begin
                    n_mode   = MODE_TEXT;
                    n_buf[0] = w_acc0;
                    n_cnt    = CNT_W'(1);
                    n_sum    = add_sum(w_sum0, w_acc0, r_sum_mode);
                end else begin
                    n_acc = {w_acc0[3:0], 4'h0} | hex_digit(r_char);
                end
            end
            default: begin
            end
        endcase

        // Frame end flushes an open bracket and returns to text.
        if (r_last) begin
            if (n_mode == MODE_HEX) begin
                n_buf[n_cnt[IDX_W-1:0]] = n_acc;
                n_cnt                   = n_cnt + CNT_W'(1);
                n_sum                   = add_sum(n_sum, n_acc, r_sum_mode);
            end
            n_mode = MODE_TEXT;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_char  <= i_char.char_code;
            r_first <= i_char.first_of_frame;
            r_last  <= i_char.last_of_frame;
        end
    end

    // Parser state and result count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_TEXT;
            r_acc  <= 8'h00;
            r_sum  <= 16'h0000;
            r_cnt  <= '0;
        end else if (w_advance) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_sum  <= n_sum;
            r_cnt  <= n_cnt;
        end else if (w_out_accept) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Result bytes: load on advance, otherwise shift toward entry zero per handshake.
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_buf <= n_buf;
        end else if (w_out_accept) begin
            for (int k = 0; k < MAX_RESULTS - 1; k++) begin
                r_buf[k] <= r_buf[k + 1];
            end
        end
    end

`ifndef NO_ASSERTIONS
    // A waiting item that cannot move into the result register blocks the input.
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |-> !i_char.ready)
        else $error("input accepted while the input register is blocked");

    // The parser is back in text mode after any frame-end item.
    a_frame_end_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_last) |=> (r_mode == MODE_TEXT))
        else $error("parser not in text mode after frame end");

    // An item that causes no byte leaves the output idle.
    a_empty_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (n_cnt == '0)) |=> !o_byte.valid)
        else $error("output valid after an item without bytes");

    // The result count never exceeds the bytes one item can cause.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |-> (n_cnt <= CNT_W'(MAX_RESULTS)))
        else $error("decode produced too many bytes");
`endif

endmodule

`default_nettype wire
